// File: rtl/core/lcbb_pkg.sv
package lcbb_pkg;

   localparam int KEY_BITS    = 32;
   localparam int SIZE_BITS   = 24;
   localparam int BUDGET_BITS = 32;
   localparam int USED_BITS   = 32;
   localparam int EVICT_BITS  = 5;
   localparam int DEF_ENTRIES = 16;

   typedef struct packed {
      logic [KEY_BITS-1:0]  item_key;
      logic [SIZE_BITS-1:0] item_size;
   } lcbb_req_type;

   typedef struct packed {
      logic                  hit;
      logic                  stored;
      logic [EVICT_BITS-1:0] evicted_count;
      logic [USED_BITS-1:0]  used_bytes;
   } lcbb_rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [SIZE_BITS-1:0] size;
   } lcbb_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_EVICT
   } lcbb_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD
   } lcbb_cell_op_type;

endpackage

// File: rtl/core/lcbb_cell.sv
module lcbb_cell import lcbb_pkg::*; (
   input  logic                 clock,
   input  lcbb_cell_op_type     cell_op,
   input  lcbb_entry_type       upper_entry,
   input  lcbb_entry_type       load_entry,
   input  logic [KEY_BITS-1:0]  probe_key,
   output lcbb_entry_type       entry,
   output logic                 match
);

   lcbb_entry_type entry_ff;
   lcbb_entry_type entry_in;

   always_comb begin
      case (cell_op)
         CELL_SHIFT: entry_in = upper_entry;
         CELL_LOAD:  entry_in = load_entry;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff.key == probe_key);

endmodule

// File: rtl/core/lru_cache_byte_budget.sv
// Size-aware LRU cache directory with a byte budget.
// A request beat is taken at a rising edge with start high and busy low; it carries the
// item key and size. Exactly one result beat follows on rsp_data, marked by rsp_valid for
// one cycle; the receiver cannot stall it. The user must write the budget through csr_we
// and csr_wdata only while the block is idle; the block itself does not enforce this.
// Entries live in a row of cells ordered by recency, the least recent in cell zero. The
// live entries always fill the low cells, so evicting the oldest entry is a shift of the
// whole row by one cell and an insert loads the first free cell.
// A hit or an oversize miss passes the lookup and decide states and gives its result beat
// on the return to idle. A stored miss goes on to the evict state, which evicts one entry
// per cycle from cell zero until the item fits and a cell is free, then loads it and gives the
// beat. busy drops in the cycle of the result beat, so the next request can be taken then.
// Synchronous reset empties the cache, clears the used byte total and the budget, and
// drops any pending result beat.
module lru_cache_byte_budget import lcbb_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lcbb_req_type           req_data,
   output logic                   rsp_valid,
   output lcbb_rsp_type           rsp_data,
   input  logic                   csr_we,
   input  logic [BUDGET_BITS-1:0] csr_wdata
);

   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   lcbb_state_type         state_ff, state_in;
   lcbb_req_type           req_ff, req_in;
   logic [BUDGET_BITS-1:0] budget_ff;
   logic [USED_BITS-1:0]   used_ff, used_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [EVICT_BITS-1:0]  evict_ff, evict_in;
   logic [ENTRIES-1:0]     match_ff, match_in;
   logic [ENTRIES-1:0]     above_ff, above_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lcbb_rsp_type           rsp_ff, rsp_in;

   lcbb_entry_type         cell_entry [ENTRIES];
   lcbb_cell_op_type       cell_op [ENTRIES];
   logic [ENTRIES-1:0]     cell_match;
   logic [ENTRIES-1:0]     live;
   lcbb_entry_type         load_entry;
   logic [SIZE_BITS-1:0]   hit_size;
   logic                   hit;
   logic                   oversize;
   logic                   over;
   logic                   full;
   logic                   do_evict;
   logic [CNT_BITS-1:0]    top_pos;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lcbb_entry_type upper;
      if (i == ENTRIES - 1) begin : g_top
         assign upper = load_entry;
      end else begin : g_mid
         assign upper = cell_entry[i+1];
      end
      assign live[i] = (CNT_BITS'(i) < count_ff);
      lcbb_cell u_cell (
         .clock       (clock),
         .cell_op     (cell_op[i]),
         .upper_entry (upper),
         .load_entry  (load_entry),
         .probe_key   (req_ff.item_key),
         .entry       (cell_entry[i]),
         .match       (cell_match[i])
      );
   end

   always_comb begin
      hit_size = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_size = hit_size | (cell_entry[i].size & {SIZE_BITS{match_ff[i]}});
      end
   end

   assign hit      = |match_ff;
   assign oversize = (BUDGET_BITS'(req_ff.item_size) > budget_ff);
   assign over     = (({1'b0, used_ff} + (USED_BITS+1)'(req_ff.item_size)) > {1'b0, budget_ff});
   assign full     = (count_ff == CNT_BITS'(ENTRIES));
   assign do_evict = (over && (count_ff != '0)) || full;
   assign top_pos  = count_ff - CNT_BITS'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (hit || oversize) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (!do_evict) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      used_in      = used_ff;
      count_in     = count_ff;
      evict_in     = evict_ff;
      match_in     = match_ff;
      above_in     = above_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      load_entry   = '{key: req_ff.item_key, size: req_ff.item_size};
      for (int i = 0; i < ENTRIES; i++) begin
         cell_op[i] = CELL_HOLD;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               evict_in = '0;
            end
         end
         ST_LOOKUP: begin
            match_in = cell_match & live;
            above_in = match_in;
            for (int s = 1; s < ENTRIES; s = s * 2) begin
               above_in = above_in | (above_in << s);
            end
         end
         ST_DECIDE: begin
            if (hit) begin
               load_entry.size = hit_size;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (above_ff[i]) begin
                     cell_op[i] = (CNT_BITS'(i) == top_pos) ? CELL_LOAD : CELL_SHIFT;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: 1'b1, stored: 1'b1, evicted_count: '0,
                                used_bytes: used_ff};
            end else if (oversize) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: 1'b0, stored: 1'b0, evicted_count: '0,
                                used_bytes: used_ff};
            end
         end
         ST_EVICT: begin
            if (do_evict) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  cell_op[i] = CELL_SHIFT;
               end
               used_in  = used_ff - USED_BITS'(cell_entry[0].size);
               count_in = count_ff - CNT_BITS'(1);
               evict_in = (evict_ff == '1) ? evict_ff : evict_ff + EVICT_BITS'(1);
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (CNT_BITS'(i) == count_ff) begin
                     cell_op[i] = CELL_LOAD;
                  end
               end
               used_in      = used_ff + USED_BITS'(req_ff.item_size);
               count_in     = count_ff + CNT_BITS'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: 1'b0, stored: 1'b1, evicted_count: evict_ff,
                                used_bytes: used_in};
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         budget_ff    <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            budget_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      evict_ff <= evict_in;
      match_ff <= match_in;
      above_ff <= above_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(ENTRIES))
      else $error("entry count exceeds the table size");

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (used_ff == '0))
      else $error("empty cache holds bytes");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat lasted more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not start work");

   a_hit_stored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.stored && (rsp_data.evicted_count == '0)))
      else $error("hit beat reports inconsistent fields");

endmodule
